/* rtl/core/scd_pkg.sv */
`timescale 1ns / 1ps
// shared constants, result types and the month start table for the date converter
// no dependencies

package scd_pkg;

    // register stages from the accepting edge to the result
    localparam int          STAGES         = 6;

    // reciprocal for seconds / 86400, applied to the seconds shifted right by 7 (x < 2^25)
    localparam logic [25:0] RECIP_DAY_HI   = 26'd50903317;
    localparam int          SHIFT_DAY_HI   = 35;
    localparam logic [9:0]  DAY_HI_DIV     = 10'd675;

    // reciprocal for seconds / 60, as / 15 after a shift by 2 (x < 2^15)
    localparam logic [15:0] RECIP_SIXTY    = 16'd34953;
    localparam int          SHIFT_SIXTY    = 19;
    // reciprocal for hours, minutes shifted by 2 (x < 2^9)
    localparam logic [9:0]  RECIP_HOUR     = 10'd547;
    localparam int          SHIFT_HOUR     = 13;
    localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;

    // four year cycle from 1990: 365, 365, 366, 365 days
    localparam logic [16:0] RECIP_CYCLE    = 17'd91868;
    localparam int          SHIFT_CYCLE    = 27;
    localparam logic [10:0] CYCLE_DAYS     = 11'd1461;
    localparam logic [10:0] YEAR1_START    = 11'd365;
    localparam logic [10:0] YEAR2_START    = 11'd730;
    localparam logic [10:0] YEAR3_START    = 11'd1096;
    localparam logic [7:0]  BASE_YEAR      = 8'd90;

    // weekday, 1990-01-01 was a monday
    localparam logic [16:0] RECIP_WEEK     = 17'd74899;
    localparam int          SHIFT_WEEK     = 19;
    localparam logic [2:0]  WEEK_DAYS      = 3'd7;

    // first second of 2100
    localparam logic [31:0] END_OF_2099    = 32'd3471292800;

    localparam logic [3:0]  MONTH_MAR      = 4'd2;
    localparam int          MONTHS         = 12;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [8:0] yday;
        logic [2:0] wday;
    } t_date;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // zero-based day of year on which a month begins
    function automatic logic [8:0] mon_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        unique case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + ((leap && (mon >= MONTH_MAR)) ? 9'd1 : 9'd0);
    endfunction

endpackage

/* rtl/core/scd_clock.sv */
`timescale 1ns / 1ps
// time of day path: seconds within the day split into hour, minute and second
// depends on scd_pkg; five register stages, no stall

module scd_clock (
    input  logic          i_clk,
    input  logic [15:0]   i_days,
    input  logic [24:0]   i_secs_hi,
    input  logic [6:0]    i_secs_lo,
    output scd_pkg::t_tod o_tod
);
    import scd_pkg::*;

    logic [24:0] day_hi_base;
    logic [30:0] mt_prod;
    logic [18:0] hr_prod;
    logic [16:0] sec_diff;
    logic [10:0] min_diff;

    logic [16:0] r_rem2;
    logic [16:0] r_rem3;
    logic [10:0] r_mt3;
    logic [10:0] r_mt4;
    logic [5:0]  r_sec4;
    logic [4:0]  r_hour4;
    logic [5:0]  r_sec5;
    logic [4:0]  r_hour5;
    logic [5:0]  r_min5;
    t_tod        r_tod;

    // remainder of the day in seconds
    assign day_hi_base = 25'(i_days) * 25'(DAY_HI_DIV);

    always_ff @(posedge i_clk) begin
        r_rem2 <= {10'(i_secs_hi - day_hi_base), i_secs_lo};
    end

    // total minutes of the day
    assign mt_prod = 31'(r_rem2[16:2]) * 31'(RECIP_SIXTY);

    always_ff @(posedge i_clk) begin
        r_rem3 <= r_rem2;
        r_mt3  <= mt_prod[SHIFT_SIXTY +: 11];
    end

    // seconds left over and hour of the day
    assign sec_diff = r_rem3 - 17'({r_mt3, 6'd0} - {2'd0, r_mt3, 2'd0});
    assign hr_prod  = 19'(r_mt3[10:2]) * 19'(RECIP_HOUR);

    always_ff @(posedge i_clk) begin
        r_mt4   <= r_mt3;
        r_sec4  <= sec_diff[5:0];
        r_hour4 <= hr_prod[SHIFT_HOUR +: 5];
    end

    // minutes left over
    assign min_diff = r_mt4 - (11'(r_hour4) * 11'(MIN_PER_HOUR));

    always_ff @(posedge i_clk) begin
        r_sec5  <= r_sec4;
        r_hour5 <= r_hour4;
        r_min5  <= min_diff[5:0];
    end

    // output stage, lines up with the date path
    always_ff @(posedge i_clk) begin
        r_tod.hour   <= r_hour5;
        r_tod.minute <= r_min5;
        r_tod.second <= r_sec5;
    end

    assign o_tod = r_tod;

endmodule

/* rtl/core/scd_calendar.sv */
`timescale 1ns / 1ps
// date path: whole days since 1990 split into year, month, day and weekday
// depends on scd_pkg; five register stages, no stall

module scd_calendar (
    input  logic           i_clk,
    input  logic [15:0]    i_days,
    output scd_pkg::t_date o_date
);
    import scd_pkg::*;

    logic [16:0] days_inc;
    logic [32:0] cyc_prod;
    logic [33:0] wk_prod;
    logic [15:0] dc_diff;
    logic [16:0] wd_diff;
    logic [1:0]  yidx;
    logic [10:0] yoff;
    logic [10:0] yday_full;
    logic [3:0]  mon_cnt;
    logic [8:0]  mday_full;

    logic [15:0] r_days2;
    logic [5:0]  r_cyc2;
    logic [12:0] r_q7;
    logic [10:0] r_dc3;
    logic [5:0]  r_cyc3;
    logic [2:0]  r_wday3;
    logic [7:0]  r_year4;
    logic [8:0]  r_yday4;
    logic        r_leap4;
    logic [2:0]  r_wday4;
    logic [7:0]  r_year5;
    logic [8:0]  r_yday5;
    logic        r_leap5;
    logic [2:0]  r_wday5;
    logic [3:0]  r_mon5;
    t_date       r_date;

    // four year cycle count and week count
    assign days_inc = {1'b0, i_days} + 17'd1;
    assign cyc_prod = 33'(i_days) * 33'(RECIP_CYCLE);
    assign wk_prod  = 34'(days_inc) * 34'(RECIP_WEEK);

    always_ff @(posedge i_clk) begin
        r_days2 <= i_days;
        r_cyc2  <= cyc_prod[SHIFT_CYCLE +: 6];
        r_q7    <= wk_prod[SHIFT_WEEK +: 13];
    end

    // day within the cycle and weekday
    assign dc_diff = r_days2 - (16'(r_cyc2) * 16'(CYCLE_DAYS));
    assign wd_diff = ({1'b0, r_days2} + 17'd1) - (17'(r_q7) * 17'(WEEK_DAYS));

    always_ff @(posedge i_clk) begin
        r_dc3   <= dc_diff[10:0];
        r_cyc3  <= r_cyc2;
        r_wday3 <= wd_diff[2:0];
    end

    // year within the cycle, the third one is the leap year
    always_comb begin
        priority if (r_dc3 < YEAR1_START) begin
            yidx = 2'd0;
            yoff = 11'd0;
        end else if (r_dc3 < YEAR2_START) begin
            yidx = 2'd1;
            yoff = YEAR1_START;
        end else if (r_dc3 < YEAR3_START) begin
            yidx = 2'd2;
            yoff = YEAR2_START;
        end else begin
            yidx = 2'd3;
            yoff = YEAR3_START;
        end
    end

    assign yday_full = r_dc3 - yoff;

    always_ff @(posedge i_clk) begin
        r_year4 <= {r_cyc3, yidx} + BASE_YEAR;
        r_yday4 <= yday_full[8:0];
        r_leap4 <= (yidx == 2'd2);
        r_wday4 <= r_wday3;
    end

    // month: count the month starts already passed
    always_comb begin
        mon_cnt = 4'd0;
        for (int m = 1; m < MONTHS; m++) begin
            if (r_yday4 >= mon_start(4'(m), r_leap4)) begin
                mon_cnt = mon_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year5 <= r_year4;
        r_yday5 <= r_yday4;
        r_leap5 <= r_leap4;
        r_wday5 <= r_wday4;
        r_mon5  <= mon_cnt;
    end

    // day of month from the month start
    assign mday_full = r_yday5 - mon_start(r_mon5, r_leap5) + 9'd1;

    always_ff @(posedge i_clk) begin
        r_date.year  <= r_year5;
        r_date.month <= r_mon5;
        r_date.mday  <= mday_full[4:0];
        r_date.yday  <= r_yday5;
        r_date.wday  <= r_wday5;
    end

    assign o_date = r_date;

endmodule

/* rtl/core/seconds_to_calendar_date.sv */
`timescale 1ns / 1ps
// top level of the seconds to calendar date converter: day split and control
// depends on scd_pkg, scd_clock and scd_calendar

// usage
//   a transaction is taken at each rising edge with start high and busy low;
//   i_seconds_since_1990 carries seconds since 1990-01-01 00:00:00 utc
//   busy is always low: one transaction can be taken in every cycle
//   the result appears after the last register stage, held for one cycle
//   and marked by o_done; the receiver has no way to stall it
//   the data passes six register stages: the day division, then on each
//   path the reciprocal multiplies and their back subtracts, the year and
//   month selection and the day of month subtract
//   o_out_of_range flags inputs from 2100-01-01 on; the other fields are
//   still filled with the every fourth year rule
//   reset (synchronous, active low) clears the valid bits, so no o_done
//   follows for transactions in flight; nothing else needs clearing

module seconds_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_seconds_since_1990,
    output logic        o_done,
    output logic [7:0]  o_year_since_1900,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [8:0]  o_day_of_year,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_day_of_week,
    output logic        o_out_of_range
);
    import scd_pkg::*;

    logic [50:0] day_prod;
    logic        accept;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] r_oor;
    logic [15:0] r_days;
    logic [24:0] r_secs_hi;
    logic [6:0]  r_secs_lo;
    t_date       date;
    t_tod        tod;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // whole days from the seconds, low seven bits divide out as a shift
    assign day_prod = 51'(i_seconds_since_1990[31:7]) * 51'(RECIP_DAY_HI);

    always_ff @(posedge i_clk) begin
        r_days    <= day_prod[SHIFT_DAY_HI +: 16];
        r_secs_hi <= i_seconds_since_1990[31:7];
        r_secs_lo <= i_seconds_since_1990[6:0];
        r_oor     <= {r_oor[STAGES-2:0], (i_seconds_since_1990 >= END_OF_2099)};
    end

    // valid bits travel with the data
    assign n_vld = {r_vld[STAGES-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    scd_clock u_clock (
        .i_clk     (i_clk),
        .i_days    (r_days),
        .i_secs_hi (r_secs_hi),
        .i_secs_lo (r_secs_lo),
        .o_tod     (tod)
    );

    scd_calendar u_calendar (
        .i_clk  (i_clk),
        .i_days (r_days),
        .o_date (date)
    );

    assign o_done            = r_vld[STAGES-1];
    assign o_year_since_1900 = date.year;
    assign o_month           = date.month;
    assign o_day_of_month    = date.mday;
    assign o_day_of_year     = date.yday;
    assign o_hour            = tod.hour;
    assign o_minute          = tod.minute;
    assign o_second          = tod.second;
    assign o_day_of_week     = date.wday;
    assign o_out_of_range    = r_oor[STAGES-1];

`ifndef SYNTHESIS
    // month and day of month stay within the calendar
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_month <= 4'd11 && o_day_of_month >= 5'd1 && o_day_of_month <= 5'd31))
        else $error("month or day of month out of range");

    // time of day and weekday stay within range
    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59
                    && o_day_of_week <= 3'd6))
        else $error("time of day or weekday out of range");

    // in-range results land no later than 2099
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_out_of_range) |-> (o_year_since_1900 <= 8'd199))
        else $error("year past 2099 without out of range flag");

    // in january the day of year follows the day of month
    a_january: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_month == 4'd0) |-> (o_day_of_year == ({4'd0, o_day_of_month} - 9'd1)))
        else $error("day of year disagrees with day of month in january");
`endif

endmodule
